@@ design/pnmh_pkg.sv @@
// ----------------------------------------------------------------------------
// pnmh_pkg
// Types, codes and keyword tables shared by the PNM/PAM header parser.
// ----------------------------------------------------------------------------
package pnmh_pkg;

  localparam int TokCap  = 64;
  localparam int TokLenW = $clog2(TokCap + 1);
  localparam int NumKw   = 13;

  localparam logic [3:0] KW_P5       = 4'd0;
  localparam logic [3:0] KW_P6       = 4'd1;
  localparam logic [3:0] KW_P7       = 4'd2;
  localparam logic [3:0] KW_ENDHDR   = 4'd3;
  localparam logic [3:0] KW_WIDTH    = 4'd4;
  localparam logic [3:0] KW_HEIGHT   = 4'd5;
  localparam logic [3:0] KW_DEPTH    = 4'd6;
  localparam logic [3:0] KW_MAXVAL   = 4'd7;
  localparam logic [3:0] KW_TUPLTYPE = 4'd8;
  localparam logic [3:0] KW_GRAY     = 4'd9;
  localparam logic [3:0] KW_RGB      = 4'd10;
  localparam logic [3:0] KW_GRAY_A   = 4'd11;
  localparam logic [3:0] KW_RGB_A    = 4'd12;
  localparam logic [3:0] KW_NONE     = 4'd13;

  localparam logic [3:0] STAT_OK          = 4'd0;
  localparam logic [3:0] STAT_NO_MAGIC    = 4'd1;
  localparam logic [3:0] STAT_BAD_MAGIC   = 4'd2;
  localparam logic [3:0] STAT_BAD_WIDTH   = 4'd3;
  localparam logic [3:0] STAT_BAD_HEIGHT  = 4'd4;
  localparam logic [3:0] STAT_BAD_DEPTH   = 4'd5;
  localparam logic [3:0] STAT_BAD_MAXVAL  = 4'd6;
  localparam logic [3:0] STAT_TRUNC_PAM   = 4'd7;
  localparam logic [3:0] STAT_NO_TUPLE    = 4'd8;
  localparam logic [3:0] STAT_UNKNOWN_KEY = 4'd9;
  localparam logic [3:0] STAT_INCOMPLETE  = 4'd10;
  localparam logic [3:0] STAT_BAD_TUPLE   = 4'd11;
  localparam logic [3:0] STAT_DEPTH_MISM  = 4'd12;
  localparam logic [3:0] STAT_SIZE        = 4'd13;

  localparam logic [4:0] SEEN_WIDTH  = 5'b00001;
  localparam logic [4:0] SEEN_HEIGHT = 5'b00010;
  localparam logic [4:0] SEEN_DEPTH  = 5'b00100;
  localparam logic [4:0] SEEN_MAXVAL = 5'b01000;
  localparam logic [4:0] SEEN_TUPLE  = 5'b10000;
  localparam logic [4:0] SEEN_ALL    = 5'b11111;

  localparam logic [2:0] TUP_NONE   = 3'd0;
  localparam logic [2:0] TUP_GRAY   = 3'd1;
  localparam logic [2:0] TUP_RGB    = 3'd2;
  localparam logic [2:0] TUP_GRAY_A = 3'd3;
  localparam logic [2:0] TUP_RGB_A  = 3'd4;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_PNM_W, PH_PNM_H, PH_PNM_MAX, PH_PAM_KEY, PH_PAM_W, PH_PAM_H,
    PH_PAM_D, PH_PAM_MAX, PH_PAM_TUPL, PH_SKIP_TAIL, PH_PAYLOAD, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_RUN, S_FLUSH, S_CHECK, S_MUL1, S_MUL2, S_MUL3, S_FINAL, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       tok_add;
    logic       tok_clear;
    logic       set_comment;
    logic       clr_comment;
    logic       cnt_inc;
    logic       cnt_one;
    logic       ld_width;
    logic       ld_height;
    logic       ld_depth;
    logic       set_pnm5;
    logic       set_pnm6;
    logic       set_tuple;
    logic [4:0] seen_set;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       ld_out;
    logic [3:0] out_status;
    logic       clr_all;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_ws;
    logic       is_hash;
    logic       is_nl;
    logic       tok_active;
    logic       too_long;
    logic       in_comment;
    logic       num_nz;
    logic       num_255;
    logic [3:0] match;
    logic       seen_all;
    logic       tuple_zero;
    logic       depth_ok;
    logic       size_ok;
  } dp_stat_t;

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      KW_P5, KW_P6, KW_P7:               n = 4'd2;
      KW_ENDHDR, KW_HEIGHT, KW_MAXVAL:   n = 4'd6;
      KW_WIDTH, KW_DEPTH:                n = 4'd5;
      KW_TUPLTYPE:                       n = 4'd8;
      KW_GRAY, KW_RGB_A:                 n = 4'd9;
      KW_RGB:                            n = 4'd3;
      KW_GRAY_A:                         n = 4'd15;
      default:                           n = 4'd0;
    endcase
    return n;
  endfunction

  // Character p of keyword k; strings are right aligned in the vector.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [127:0] s;
    logic [3:0]   idx;
    case (k)
      KW_P5:       s = 128'("P5");
      KW_P6:       s = 128'("P6");
      KW_P7:       s = 128'("P7");
      KW_ENDHDR:   s = 128'("ENDHDR");
      KW_WIDTH:    s = 128'("WIDTH");
      KW_HEIGHT:   s = 128'("HEIGHT");
      KW_DEPTH:    s = 128'("DEPTH");
      KW_MAXVAL:   s = 128'("MAXVAL");
      KW_TUPLTYPE: s = 128'("TUPLTYPE");
      KW_GRAY:     s = 128'("GRAYSCALE");
      KW_RGB:      s = 128'("RGB");
      KW_GRAY_A:   s = 128'({"GRAYSCALE", "_ALPHA"});
      KW_RGB_A:    s = 128'({"RGB", "_ALPHA"});
      default:     s = '0;
    endcase
    idx = kw_len(k) - 4'd1 - p;
    return s[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] missing_code(input phase_t ph);
    logic [3:0] c;
    case (ph)
      PH_MAGIC:    c = STAT_NO_MAGIC;
      PH_PNM_W:    c = STAT_BAD_WIDTH;
      PH_PNM_H:    c = STAT_BAD_HEIGHT;
      PH_PNM_MAX:  c = STAT_BAD_MAXVAL;
      PH_PAM_KEY:  c = STAT_TRUNC_PAM;
      PH_PAM_W:    c = STAT_BAD_WIDTH;
      PH_PAM_H:    c = STAT_BAD_HEIGHT;
      PH_PAM_D:    c = STAT_BAD_DEPTH;
      PH_PAM_MAX:  c = STAT_BAD_MAXVAL;
      PH_PAM_TUPL: c = STAT_NO_TUPLE;
      default:     c = STAT_OK;
    endcase
    return c;
  endfunction

endpackage

@@ design/pnmh_channels.sv @@
// ----------------------------------------------------------------------------
// pnmh channels
// Valid/ready channels for file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface pnmh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface pnmh_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] width;
  logic [31:0] height;
  logic [31:0] channels;
  logic [1:0]  color_channels;
  logic        extra_channels;

  modport source (output valid, output status, output width, output height,
                  output channels, output color_channels, output extra_channels,
                  input ready);
  modport sink (input valid, input status, input width, input height,
                input channels, input color_channels, input extra_channels,
                output ready);
endinterface

@@ design/pnm_pam_header_parser.sv @@
// ----------------------------------------------------------------------------
// pnm_pam_header_parser
// Streaming header parser for binary P5, P6 and P7 (PAM) image files.
// ----------------------------------------------------------------------------
// byte_chan carries the file one byte per item, last_byte set on the final
// byte. result_chan returns one item per file: a status code and, when the
// status is ok, the width, height, samples per pixel, color channels and
// alpha flag; otherwise those fields are zero.
// Header and payload bytes are taken at one byte per cycle while no earlier
// file is still being closed or awaiting its result. After the final byte
// the block stops taking bytes while it closes any open token, checks for
// a missing token and, for a complete header, forms width*height*channels
// modulo 2^64 in three steps with one 32x32 multiply per step and compares
// it with the payload count.
// The result register holds its item while result_chan is stalled; no new
// byte is accepted until it is taken. Reset (rst, synchronous) returns the
// parser to expecting a magic word, with no result pending.
// ----------------------------------------------------------------------------
module pnm_pam_header_parser (
  input logic                  clk,
  input logic                  rst,
  pnmh_byte_if.sink            byte_chan,
  pnmh_result_if.source        result_chan
);

  pnmh_pkg::dp_cmd_t  cmd;
  pnmh_pkg::dp_stat_t stat;

  pnmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_chan.valid),
    .in_last   (byte_chan.last_byte),
    .in_ready  (byte_chan.ready),
    .out_valid (result_chan.valid),
    .out_ready (result_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pnmh_datapath u_datapath (
    .clk            (clk),
    .byte_in        (byte_chan.byte_in),
    .cmd            (cmd),
    .stat           (stat),
    .status         (result_chan.status),
    .width          (result_chan.width),
    .height         (result_chan.height),
    .channels       (result_chan.channels),
    .color_channels (result_chan.color_channels),
    .extra_channels (result_chan.extra_channels),
    .rst            (rst)
  );

endmodule

@@ design/pnmh_datapath.sv @@
// ----------------------------------------------------------------------------
// pnmh_datapath
// Tokenizer, keyword matcher, number accumulator, header values, payload
// counter, size multiplier and result register.
// ----------------------------------------------------------------------------
module pnmh_datapath (
  input  logic                clk,
  input  logic [7:0]          byte_in,
  input  pnmh_pkg::dp_cmd_t   cmd,
  output pnmh_pkg::dp_stat_t  stat,
  output logic [3:0]          status,
  output logic [31:0]         width,
  output logic [31:0]         height,
  output logic [31:0]         channels,
  output logic [1:0]          color_channels,
  output logic                extra_channels,
  input  logic                rst
);

  localparam int TokLenW = pnmh_pkg::TokLenW;

  logic [pnmh_pkg::TokLenW-1:0] tok_len, tok_len_next, base_len;
  logic [pnmh_pkg::NumKw-1:0]   cand, cand_next, base_cand;
  logic [32:0]                  acc, acc_next, base_acc;
  logic [36:0]                  acc10;
  logic                         f_digit, f_neg, f_bad;
  logic                         f_digit_next, f_neg_next, f_bad_next;
  logic                         in_comment;
  logic [31:0]                  width_value, height_value, depth_value;
  logic [4:0]                   seen;
  logic [2:0]                   tuple_code, tuple_m;
  logic [63:0]                  payload_count;
  logic [63:0]                  prod, part_lo;
  logic [31:0]                  part_hi;
  logic                         num;
  logic [31:0]                  v;
  logic [3:0]                   match;
  logic [31:0]                  depth_expect;
  logic                         is_digit;

  assign is_digit = (byte_in >= "0") && (byte_in <= "9");

  // Token update: a clear in the same cycle restarts from the reset values.
  always_comb begin
    base_len  = cmd.tok_clear ? '0 : tok_len;
    base_cand = cmd.tok_clear ? '1 : cand;
    base_acc  = cmd.tok_clear ? '0 : acc;
    f_digit_next = cmd.tok_clear ? 1'b0 : f_digit;
    f_neg_next   = cmd.tok_clear ? 1'b0 : f_neg;
    f_bad_next   = cmd.tok_clear ? 1'b0 : f_bad;
    cand_next    = base_cand;
    acc_next     = base_acc;
    tok_len_next = base_len;
    acc10 = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + 37'(byte_in[3:0]);
    if (cmd.tok_add) begin
      for (int k = 0; k < pnmh_pkg::NumKw; k++) begin
        if (!(base_len < TokLenW'(pnmh_pkg::kw_len(4'(k)))) ||
            pnmh_pkg::kw_char(4'(k), base_len[3:0]) != byte_in) begin
          cand_next[k] = 1'b0;
        end
      end
      if (is_digit) begin
        if (acc10 > 37'hFFFF_FFFF) begin
          acc_next   = 33'h1_0000_0000;
          f_bad_next = 1'b1;
        end else begin
          acc_next = acc10[32:0];
        end
        f_digit_next = 1'b1;
      end else if (base_len == '0 && (byte_in == "+" || byte_in == "-")) begin
        if (byte_in == "-") begin
          f_neg_next = 1'b1;
        end
      end else begin
        f_bad_next = 1'b1;
      end
      if (base_len < TokLenW'(pnmh_pkg::TokCap)) begin
        tok_len_next = base_len + 1'b1;
      end
    end
  end

  always_comb begin
    match = pnmh_pkg::KW_NONE;
    for (int k = pnmh_pkg::NumKw - 1; k >= 0; k--) begin
      if (cand[k] && tok_len == TokLenW'(pnmh_pkg::kw_len(4'(k)))) begin
        match = 4'(k);
      end
    end
    if (stat.too_long) begin
      match = pnmh_pkg::KW_NONE;
    end
    case (match)
      pnmh_pkg::KW_GRAY:   tuple_m = pnmh_pkg::TUP_GRAY;
      pnmh_pkg::KW_RGB:    tuple_m = pnmh_pkg::TUP_RGB;
      pnmh_pkg::KW_GRAY_A: tuple_m = pnmh_pkg::TUP_GRAY_A;
      pnmh_pkg::KW_RGB_A:  tuple_m = pnmh_pkg::TUP_RGB_A;
      default:             tuple_m = pnmh_pkg::TUP_NONE;
    endcase
    case (tuple_code)
      pnmh_pkg::TUP_GRAY:   depth_expect = 32'd1;
      pnmh_pkg::TUP_RGB:    depth_expect = 32'd3;
      pnmh_pkg::TUP_GRAY_A: depth_expect = 32'd2;
      default:              depth_expect = 32'd4;
    endcase
  end

  assign v   = acc[31:0];
  assign num = !stat.too_long && f_digit && !f_bad && (!f_neg || acc == '0);

  always_comb begin
    stat.is_ws      = byte_in == 8'd32 || (byte_in >= 8'd9 && byte_in <= 8'd13);
    stat.is_hash    = byte_in == "#";
    stat.is_nl      = byte_in == 8'd10;
    stat.tok_active = tok_len != '0;
    stat.too_long   = tok_len >= TokLenW'(pnmh_pkg::TokCap);
    stat.in_comment = in_comment;
    stat.num_nz     = num && v != '0;
    stat.num_255    = num && v == 32'd255;
    stat.match      = match;
    stat.seen_all   = seen == pnmh_pkg::SEEN_ALL;
    stat.tuple_zero = tuple_code == pnmh_pkg::TUP_NONE;
    stat.depth_ok   = depth_value == depth_expect;
    stat.size_ok    = payload_count == (part_lo + {part_hi, 32'b0});
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      tok_len       <= '0;
      cand          <= '1;
      acc           <= '0;
      f_digit       <= 1'b0;
      f_neg         <= 1'b0;
      f_bad         <= 1'b0;
      in_comment    <= 1'b0;
      width_value   <= '0;
      height_value  <= '0;
      depth_value   <= '0;
      seen          <= '0;
      tuple_code    <= pnmh_pkg::TUP_NONE;
      payload_count <= '0;
    end else begin
      tok_len <= tok_len_next;
      cand    <= cand_next;
      acc     <= acc_next;
      f_digit <= f_digit_next;
      f_neg   <= f_neg_next;
      f_bad   <= f_bad_next;
      if (cmd.set_comment) begin
        in_comment <= 1'b1;
      end else if (cmd.clr_comment) begin
        in_comment <= 1'b0;
      end
      if (cmd.ld_width) begin
        width_value <= v;
      end
      if (cmd.ld_height) begin
        height_value <= v;
      end
      if (cmd.ld_depth) begin
        depth_value <= v;
      end else if (cmd.set_pnm5) begin
        depth_value <= 32'd1;
      end else if (cmd.set_pnm6) begin
        depth_value <= 32'd3;
      end
      if (cmd.set_tuple) begin
        tuple_code <= tuple_m;
      end else if (cmd.set_pnm5) begin
        tuple_code <= pnmh_pkg::TUP_GRAY;
      end else if (cmd.set_pnm6) begin
        tuple_code <= pnmh_pkg::TUP_RGB;
      end
      seen <= seen | cmd.seen_set;
      if (cmd.cnt_one) begin
        payload_count <= 64'd1;
      end else if (cmd.cnt_inc) begin
        payload_count <= payload_count + 64'd1;
      end
    end
  end

  // Size product modulo 2^64, one 32x32 multiply per step.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod <= 64'(width_value) * 64'(height_value);
    end
    if (cmd.mul2) begin
      part_lo <= 64'(prod[31:0]) * 64'(depth_value);
    end
    if (cmd.mul3) begin
      part_hi <= 32'(64'(prod[63:32]) * 64'(depth_value));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      status <= cmd.out_status;
      if (cmd.out_status == pnmh_pkg::STAT_OK) begin
        width    <= width_value;
        height   <= height_value;
        channels <= depth_value;
        color_channels <= (tuple_code == pnmh_pkg::TUP_GRAY ||
                           tuple_code == pnmh_pkg::TUP_GRAY_A) ? 2'd1 : 2'd3;
        extra_channels <= tuple_code >= pnmh_pkg::TUP_GRAY_A;
      end else begin
        width          <= '0;
        height         <= '0;
        channels       <= '0;
        color_channels <= '0;
        extra_channels <= 1'b0;
      end
    end
  end

endmodule

@@ design/pnmh_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnmh_ctrl
// Header phase machine and sequencer for flush, size check and result.
// ----------------------------------------------------------------------------
module pnmh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pnmh_pkg::dp_stat_t stat,
  output pnmh_pkg::dp_cmd_t  cmd
);

  pnmh_pkg::ctrl_state_t state, state_next;
  pnmh_pkg::phase_t      phase, phase_next, ph_mid;
  logic [3:0]            err, err_next;
  logic                  accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = state == pnmh_pkg::S_RUN;
  assign out_valid = state == pnmh_pkg::S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnmh_pkg::S_RUN;
      phase <= pnmh_pkg::PH_MAGIC;
      err   <= pnmh_pkg::STAT_OK;
    end else begin
      state <= state_next;
      phase <= phase_next;
      err   <= err_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    err_next   = err;
    ph_mid     = phase;
    cmd        = '0;
    case (state)
      pnmh_pkg::S_RUN: begin
        if (accept) begin
          if (in_last) begin
            state_next = pnmh_pkg::S_FLUSH;
          end
          if (phase == pnmh_pkg::PH_PAYLOAD) begin
            cmd.cnt_inc = 1'b1;
          end else if (phase != pnmh_pkg::PH_DONE) begin
            if (stat.in_comment) begin
              cmd.clr_comment = stat.is_nl;
            end else if (stat.tok_active && !stat.is_ws && !stat.is_hash) begin
              cmd.tok_add = 1'b1;
            end else begin
              if (stat.tok_active) begin
                end_token();
              end
              // Between tokens, on the phase that the ended token left.
              if (ph_mid != pnmh_pkg::PH_DONE && !stat.is_ws) begin
                if (stat.is_hash) begin
                  cmd.set_comment = 1'b1;
                end else if (ph_mid == pnmh_pkg::PH_SKIP_TAIL) begin
                  cmd.cnt_one = 1'b1;
                  ph_mid      = pnmh_pkg::PH_PAYLOAD;
                end else begin
                  cmd.tok_add = 1'b1;
                end
              end
              phase_next = ph_mid;
            end
          end
        end
      end
      pnmh_pkg::S_FLUSH: begin
        if (phase inside {[pnmh_pkg::PH_MAGIC:pnmh_pkg::PH_PAM_TUPL]} && stat.tok_active) begin
          end_token();
          phase_next = ph_mid;
        end
        state_next = pnmh_pkg::S_CHECK;
      end
      pnmh_pkg::S_CHECK: begin
        if (phase inside {[pnmh_pkg::PH_MAGIC:pnmh_pkg::PH_PAM_TUPL]}) begin
          cmd.ld_out     = 1'b1;
          cmd.out_status = pnmh_pkg::missing_code(phase);
          cmd.clr_all    = 1'b1;
          state_next     = pnmh_pkg::S_OUT;
        end else if (phase == pnmh_pkg::PH_DONE) begin
          cmd.ld_out     = 1'b1;
          cmd.out_status = err;
          cmd.clr_all    = 1'b1;
          state_next     = pnmh_pkg::S_OUT;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = pnmh_pkg::S_MUL1;
        end
      end
      pnmh_pkg::S_MUL1: begin
        cmd.mul2   = 1'b1;
        state_next = pnmh_pkg::S_MUL2;
      end
      pnmh_pkg::S_MUL2: begin
        cmd.mul3   = 1'b1;
        state_next = pnmh_pkg::S_MUL3;
      end
      pnmh_pkg::S_MUL3: begin
        state_next = pnmh_pkg::S_FINAL;
      end
      pnmh_pkg::S_FINAL: begin
        cmd.ld_out     = 1'b1;
        cmd.out_status = stat.size_ok ? pnmh_pkg::STAT_OK : pnmh_pkg::STAT_SIZE;
        cmd.clr_all    = 1'b1;
        state_next     = pnmh_pkg::S_OUT;
      end
      pnmh_pkg::S_OUT: begin
        if (out_ready) begin
          phase_next = pnmh_pkg::PH_MAGIC;
          err_next   = pnmh_pkg::STAT_OK;
          state_next = pnmh_pkg::S_RUN;
        end
      end
      default: begin
        state_next = pnmh_pkg::S_RUN;
      end
    endcase
  end

  // Close the token in progress: fills ph_mid, err_next and commands.
  function automatic void end_token();
    cmd.tok_clear = 1'b1;
    case (phase)
      pnmh_pkg::PH_MAGIC: begin
        if (stat.too_long) begin
          fail(pnmh_pkg::STAT_NO_MAGIC);
        end else if (stat.match == pnmh_pkg::KW_P5) begin
          cmd.set_pnm5 = 1'b1;
          ph_mid       = pnmh_pkg::PH_PNM_W;
        end else if (stat.match == pnmh_pkg::KW_P6) begin
          cmd.set_pnm6 = 1'b1;
          ph_mid       = pnmh_pkg::PH_PNM_W;
        end else if (stat.match == pnmh_pkg::KW_P7) begin
          ph_mid = pnmh_pkg::PH_PAM_KEY;
        end else begin
          fail(pnmh_pkg::STAT_BAD_MAGIC);
        end
      end
      pnmh_pkg::PH_PNM_W: begin
        if (stat.num_nz) begin
          cmd.ld_width = 1'b1;
          ph_mid       = pnmh_pkg::PH_PNM_H;
        end else begin
          fail(pnmh_pkg::STAT_BAD_WIDTH);
        end
      end
      pnmh_pkg::PH_PNM_H: begin
        if (stat.num_nz) begin
          cmd.ld_height = 1'b1;
          ph_mid        = pnmh_pkg::PH_PNM_MAX;
        end else begin
          fail(pnmh_pkg::STAT_BAD_HEIGHT);
        end
      end
      pnmh_pkg::PH_PNM_MAX: begin
        if (stat.num_255) begin
          ph_mid = pnmh_pkg::PH_SKIP_TAIL;
        end else begin
          fail(pnmh_pkg::STAT_BAD_MAXVAL);
        end
      end
      pnmh_pkg::PH_PAM_KEY: begin
        if (stat.too_long) begin
          fail(pnmh_pkg::STAT_TRUNC_PAM);
        end else begin
          case (stat.match)
            pnmh_pkg::KW_ENDHDR: begin
              if (!stat.seen_all) begin
                fail(pnmh_pkg::STAT_INCOMPLETE);
              end else if (stat.tuple_zero) begin
                fail(pnmh_pkg::STAT_BAD_TUPLE);
              end else if (!stat.depth_ok) begin
                fail(pnmh_pkg::STAT_DEPTH_MISM);
              end else begin
                ph_mid = pnmh_pkg::PH_SKIP_TAIL;
              end
            end
            pnmh_pkg::KW_WIDTH:    ph_mid = pnmh_pkg::PH_PAM_W;
            pnmh_pkg::KW_HEIGHT:   ph_mid = pnmh_pkg::PH_PAM_H;
            pnmh_pkg::KW_DEPTH:    ph_mid = pnmh_pkg::PH_PAM_D;
            pnmh_pkg::KW_MAXVAL:   ph_mid = pnmh_pkg::PH_PAM_MAX;
            pnmh_pkg::KW_TUPLTYPE: ph_mid = pnmh_pkg::PH_PAM_TUPL;
            default:               fail(pnmh_pkg::STAT_UNKNOWN_KEY);
          endcase
        end
      end
      pnmh_pkg::PH_PAM_W: begin
        if (stat.num_nz) begin
          cmd.ld_width = 1'b1;
          cmd.seen_set = pnmh_pkg::SEEN_WIDTH;
          ph_mid       = pnmh_pkg::PH_PAM_KEY;
        end else begin
          fail(pnmh_pkg::STAT_BAD_WIDTH);
        end
      end
      pnmh_pkg::PH_PAM_H: begin
        if (stat.num_nz) begin
          cmd.ld_height = 1'b1;
          cmd.seen_set  = pnmh_pkg::SEEN_HEIGHT;
          ph_mid        = pnmh_pkg::PH_PAM_KEY;
        end else begin
          fail(pnmh_pkg::STAT_BAD_HEIGHT);
        end
      end
      pnmh_pkg::PH_PAM_D: begin
        if (stat.num_nz) begin
          cmd.ld_depth = 1'b1;
          cmd.seen_set = pnmh_pkg::SEEN_DEPTH;
          ph_mid       = pnmh_pkg::PH_PAM_KEY;
        end else begin
          fail(pnmh_pkg::STAT_BAD_DEPTH);
        end
      end
      pnmh_pkg::PH_PAM_MAX: begin
        if (stat.num_255) begin
          cmd.seen_set = pnmh_pkg::SEEN_MAXVAL;
          ph_mid       = pnmh_pkg::PH_PAM_KEY;
        end else begin
          fail(pnmh_pkg::STAT_BAD_MAXVAL);
        end
      end
      pnmh_pkg::PH_PAM_TUPL: begin
        if (stat.too_long) begin
          fail(pnmh_pkg::STAT_NO_TUPLE);
        end else begin
          cmd.set_tuple = 1'b1;
          cmd.seen_set  = pnmh_pkg::SEEN_TUPLE;
          ph_mid        = pnmh_pkg::PH_PAM_KEY;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void fail(input logic [3:0] code);
    err_next = code;
    ph_mid   = pnmh_pkg::PH_DONE;
  endfunction

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the PNM/PAM header parser. The bench streams files one byte per
// item: a table of short directed files first, then random files that are
// mostly well formed with random sizes, separators and comments, and the
// rest damaged by cut points, bad values, bad keys or overlong tokens.
// A predictor rebuilds the parse state from the accepted bytes and queues
// one expected result per file. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import pnmh_pkg::*;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] channels;
    logic [1:0]  color_channels;
    logic        extra_channels;
  } hdr_result_t;

  typedef struct {
    logic [7:0]  b;
    bit          last;
    bit          typed;
    hdr_result_t res;
  } file_byte_t;

  typedef struct {
    string       txt;
    bit          typed;
    hdr_result_t res;
  } dir_row_t;

  localparam int StallLimit = 1000;

  logic clk;
  logic rst;
  bit   calm;
  int   nerr;
  int   idle_cycles;
  int   fed;

  file_byte_t  file_bytes[$];
  hdr_result_t results_due[$];
  dir_row_t    dir_tab[$];

  pnmh_byte_if   bi ();
  pnmh_result_if ri ();

  pnm_pam_header_parser dut (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (bi),
    .result_chan (ri)
  );

  // --------------------------------------------------------------------------
  // header predictor
  // --------------------------------------------------------------------------
  // Tuple type name with the alpha suffix.
  function automatic string with_alpha(string s);
    return {s, "_ALPHA"};
  endfunction

  string kw_names[NumKw] = '{"P5", "P6", "P7", "ENDHDR", "WIDTH", "HEIGHT", "DEPTH",
                             "MAXVAL", "TUPLTYPE", "GRAYSCALE", "RGB",
                             with_alpha("GRAYSCALE"), with_alpha("RGB")};

  phase_t          p_phase;
  int unsigned     p_tlen;
  logic [12:0]     p_cand;
  bit              p_comment;
  longint unsigned p_acc;
  bit              p_dig, p_neg, p_bad;
  logic [31:0]     p_w, p_h, p_d;
  logic [4:0]      p_seen;
  logic [2:0]      p_tup;
  logic [63:0]     p_count;
  logic [3:0]      p_err;

  function automatic void hdr_reset();
    p_phase = PH_MAGIC;
    p_tlen = 0;
    p_cand = '1;
    p_comment = 0;
    p_acc = 0;
    {p_dig, p_neg, p_bad} = '0;
    p_w = '0;
    p_h = '0;
    p_d = '0;
    p_seen = '0;
    p_tup = TUP_NONE;
    p_count = '0;
    p_err = STAT_OK;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void hdr_fail(logic [3:0] code);
    p_err = code;
    p_phase = PH_DONE;
  endfunction

  function automatic void tok_push(logic [7:0] c);
    for (int k = 0; k < NumKw; k++) begin
      if (p_cand[k] && (p_tlen >= kw_names[k].len() || kw_names[k][p_tlen] != c))
        p_cand[k] = 1'b0;
    end
    if (c >= "0" && c <= "9") begin
      p_acc = p_acc * 10 + (c - "0");
      if (p_acc > 64'hFFFF_FFFF) begin
        p_acc = 64'h1_0000_0000;
        p_bad = 1;
      end
      p_dig = 1;
    end else if (p_tlen == 0 && (c == "+" || c == "-")) begin
      if (c == "-") p_neg = 1;
    end else begin
      p_bad = 1;
    end
    if (p_tlen < TokCap) p_tlen++;
  endfunction

  function automatic logic [3:0] tok_keyword();
    if (p_tlen >= TokCap) return KW_NONE;
    for (int k = 0; k < NumKw; k++)
      if (p_cand[k] && kw_names[k].len() == p_tlen) return 4'(k);
    return KW_NONE;
  endfunction

  function automatic void take_num(bit ok, logic [3:0] code, logic [4:0] seen_bit,
                                   ref logic [31:0] dst, input logic [31:0] v,
                                   input phase_t nxt);
    if (!ok) begin
      hdr_fail(code);
      return;
    end
    dst = v;
    p_seen |= seen_bit;
    p_phase = nxt;
  endfunction

  function automatic void tok_close();
    bit          too_long;
    bit          num;
    logic [31:0] v;
    logic [3:0]  m;
    logic [31:0] color;
    logic [31:0] extra;
    too_long = p_tlen >= TokCap;
    num = !too_long && p_dig && !p_bad && (!p_neg || p_acc == 0);
    v = p_acc[31:0];
    m = tok_keyword();
    case (p_phase)
      PH_MAGIC: begin
        if (too_long) hdr_fail(STAT_NO_MAGIC);
        else if (m == KW_P5) begin
          p_d = 1; p_tup = TUP_GRAY; p_phase = PH_PNM_W;
        end else if (m == KW_P6) begin
          p_d = 3; p_tup = TUP_RGB; p_phase = PH_PNM_W;
        end else if (m == KW_P7) p_phase = PH_PAM_KEY;
        else hdr_fail(STAT_BAD_MAGIC);
      end
      PH_PNM_W: take_num(num && v != 0, STAT_BAD_WIDTH, '0, p_w, v, PH_PNM_H);
      PH_PNM_H: take_num(num && v != 0, STAT_BAD_HEIGHT, '0, p_h, v, PH_PNM_MAX);
      PH_PNM_MAX: begin
        if (num && v == 255) p_phase = PH_SKIP_TAIL;
        else hdr_fail(STAT_BAD_MAXVAL);
      end
      PH_PAM_KEY: begin
        if (too_long) hdr_fail(STAT_TRUNC_PAM);
        else if (m == KW_ENDHDR) begin
          color = (p_tup == TUP_GRAY || p_tup == TUP_GRAY_A) ? 1 : 3;
          extra = (p_tup >= TUP_GRAY_A) ? 1 : 0;
          if (p_seen != SEEN_ALL) hdr_fail(STAT_INCOMPLETE);
          else if (p_tup == TUP_NONE) hdr_fail(STAT_BAD_TUPLE);
          else if (p_d != color + extra) hdr_fail(STAT_DEPTH_MISM);
          else p_phase = PH_SKIP_TAIL;
        end
        else if (m == KW_WIDTH) p_phase = PH_PAM_W;
        else if (m == KW_HEIGHT) p_phase = PH_PAM_H;
        else if (m == KW_DEPTH) p_phase = PH_PAM_D;
        else if (m == KW_MAXVAL) p_phase = PH_PAM_MAX;
        else if (m == KW_TUPLTYPE) p_phase = PH_PAM_TUPL;
        else hdr_fail(STAT_UNKNOWN_KEY);
      end
      PH_PAM_W: take_num(num && v != 0, STAT_BAD_WIDTH, SEEN_WIDTH, p_w, v, PH_PAM_KEY);
      PH_PAM_H: take_num(num && v != 0, STAT_BAD_HEIGHT, SEEN_HEIGHT, p_h, v, PH_PAM_KEY);
      PH_PAM_D: take_num(num && v != 0, STAT_BAD_DEPTH, SEEN_DEPTH, p_d, v, PH_PAM_KEY);
      PH_PAM_MAX: begin
        if (num && v == 255) begin
          p_seen |= SEEN_MAXVAL;
          p_phase = PH_PAM_KEY;
        end else hdr_fail(STAT_BAD_MAXVAL);
      end
      PH_PAM_TUPL: begin
        if (too_long) hdr_fail(STAT_NO_TUPLE);
        else begin
          case (m)
            KW_GRAY:   p_tup = TUP_GRAY;
            KW_RGB:    p_tup = TUP_RGB;
            KW_GRAY_A: p_tup = TUP_GRAY_A;
            KW_RGB_A:  p_tup = TUP_RGB_A;
            default:   p_tup = TUP_NONE;
          endcase
          p_seen |= SEEN_TUPLE;
          p_phase = PH_PAM_KEY;
        end
      end
      default: ;
    endcase
    p_tlen = 0;
    p_cand = '1;
    p_acc = 0;
    {p_dig, p_neg, p_bad} = '0;
  endfunction

  function automatic void hdr_byte(logic [7:0] c);
    if (p_phase == PH_DONE) return;
    if (p_phase == PH_PAYLOAD) begin
      p_count++;
      return;
    end
    if (p_comment) begin
      if (c == 8'd10) p_comment = 0;
      return;
    end
    if (p_tlen > 0) begin
      if (!is_space(c) && c != "#") begin
        tok_push(c);
        return;
      end
      tok_close();
      if (p_phase == PH_DONE) return;
    end
    if (is_space(c)) return;
    if (c == "#") begin
      p_comment = 1;
      return;
    end
    if (p_phase == PH_SKIP_TAIL) begin
      p_count = 1;
      p_phase = PH_PAYLOAD;
      return;
    end
    tok_push(c);
  endfunction

  function automatic logic [3:0] absent_code(phase_t ph);
    case (ph)
      PH_MAGIC:              return STAT_NO_MAGIC;
      PH_PNM_W, PH_PAM_W:    return STAT_BAD_WIDTH;
      PH_PNM_H, PH_PAM_H:    return STAT_BAD_HEIGHT;
      PH_PAM_D:              return STAT_BAD_DEPTH;
      PH_PNM_MAX, PH_PAM_MAX: return STAT_BAD_MAXVAL;
      PH_PAM_KEY:            return STAT_TRUNC_PAM;
      default:               return STAT_NO_TUPLE;
    endcase
  endfunction

  function automatic hdr_result_t hdr_close();
    hdr_result_t r;
    logic [63:0] prod;
    r = '0;
    if (p_phase <= PH_PAM_TUPL && p_tlen > 0) tok_close();
    if (p_phase <= PH_PAM_TUPL) hdr_fail(absent_code(p_phase));
    if (p_phase == PH_DONE) r.status = p_err;
    else begin
      prod = 64'(p_w) * 64'(p_h) * 64'(p_d);
      r.status = (p_count == prod) ? STAT_OK : STAT_SIZE;
    end
    if (r.status == STAT_OK) begin
      r.width = p_w;
      r.height = p_h;
      r.channels = p_d;
      r.color_channels = (p_tup == TUP_GRAY || p_tup == TUP_GRAY_A) ? 2'd1 : 2'd3;
      r.extra_channels = p_tup >= TUP_GRAY_A;
    end
    hdr_reset();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // file builders
  // --------------------------------------------------------------------------
  function automatic void put_str(string s);
    file_byte_t fb;
    fb = '{b: 8'd0, last: 0, typed: 0, res: '0};
    foreach (s[i]) begin
      fb.b = s[i];
      file_bytes.push_back(fb);
    end
  endfunction

  function automatic string repeat_str(string s, int n);
    string t;
    t = "";
    repeat (n) t = {t, s};
    return t;
  endfunction

  function automatic string space_char();
    byte unsigned ws[6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    string t;
    t = " ";
    t[0] = ws[$urandom_range(0, 5)];
    return t;
  endfunction

  // Separator: whitespace runs, sometimes a comment out to end of line.
  function automatic void put_sep();
    string t;
    t = space_char();
    if ($urandom_range(0, 7) == 0) begin
      t = {t, "#"};
      repeat ($urandom_range(0, 6)) t = {t, string'(byte'($urandom_range(33, 126)))};
      t = {t, "\n"};
    end
    if ($urandom_range(0, 3) == 0) t = {t, space_char()};
    put_str(t);
  endfunction

  function automatic string num_text(int unsigned v, bit mut);
    string dec;
    dec = $sformatf("%0d", v);
    if (mut) begin
      case ($urandom_range(0, 5))
        0: return "-0";
        1: return "4294967296";
        2: return "0";
        3: return "-1";
        4: return "1x";
        default: return "99999999999";
      endcase
    end
    case ($urandom_range(0, 9))
      0: return {"+", dec};
      1: return {"00", dec};
      default: return dec;
    endcase
  endfunction

  function automatic void gen_file();
    int          start;
    int          kind;
    bit          mut;
    int          w, h, ch, tup, n, cut;
    int          order[5];
    string       tnames[4] = '{"GRAYSCALE", "RGB", with_alpha("GRAYSCALE"),
                               with_alpha("RGB")};
    start = file_bytes.size();
    mut = $urandom_range(0, 3) == 0;
    kind = $urandom_range(0, 2);
    w = $urandom_range(1, 3);
    h = $urandom_range(1, 3);
    if (mut && $urandom_range(0, 4) == 0) begin
      // long token (60 to 68 characters) in one of the token slots
      case ($urandom_range(0, 3))
        0: put_str("");
        1: put_str("P7\n");
        2: put_str("P7\nTUPLTYPE ");
        default: put_str("P5 ");
      endcase
      put_str(repeat_str($urandom_range(0, 1) ? "A" : "7", $urandom_range(60, 68)));
      if ($urandom_range(0, 1)) put_str(" 1 1 255\nZ");
    end else if (kind < 2) begin
      ch = kind ? 3 : 1;
      put_str(kind ? "P6" : "P5");
      put_sep();
      put_str(num_text(w, mut && $urandom_range(0, 3) == 0));
      put_sep();
      put_str(num_text(h, mut && $urandom_range(0, 3) == 0));
      put_sep();
      put_str((mut && $urandom_range(0, 3) == 0) ? "254" : "255");
      put_str(space_char());
    end else begin
      tup = $urandom_range(0, 3);
      ch = ((tup == 0 || tup == 2) ? 1 : 3) + (tup >= 2 ? 1 : 0);
      put_str("P7");
      put_sep();
      for (int i = 0; i < 5; i++) order[i] = i;
      for (int i = 4; i > 0; i--) begin
        int j, t;
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      foreach (order[i]) begin
        if (mut && $urandom_range(0, 7) == 0) continue;
        case (order[i])
          0: put_str({"WIDTH", space_char(), num_text(w, mut && $urandom_range(0, 5) == 0)});
          1: put_str({"HEIGHT", space_char(), num_text(h, mut && $urandom_range(0, 5) == 0)});
          2: put_str({"DEPTH", space_char(),
                      num_text((mut && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : ch,
                               mut && $urandom_range(0, 5) == 0)});
          3: put_str({"MAXVAL", space_char(), (mut && $urandom_range(0, 5) == 0) ? "256" : "255"});
          default: put_str({"TUPLTYPE", space_char(),
                            (mut && $urandom_range(0, 4) == 0) ? "BLUE" : tnames[tup]});
        endcase
        put_sep();
        if (mut && $urandom_range(0, 9) == 0) begin
          put_str((order[i] == 0) ? "WIDTHS 1" : "HEIGHT 2");
          put_sep();
        end
      end
      put_str("ENDHDR");
      put_str(space_char());
    end
    n = w * h * ch;
    if (mut && $urandom_range(0, 2) == 0) n = n + $urandom_range(0, 2) - 1;
    for (int i = 0; i < n; i++) begin
      file_byte_t fb;
      fb = '{b: 8'($urandom_range(0, 255)), last: 0, typed: 0, res: '0};
      file_bytes.push_back(fb);
    end
    if (mut && $urandom_range(0, 2) == 0) begin
      cut = start + $urandom_range(1, file_bytes.size() - start);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    if (mut && $urandom_range(0, 2) == 0)
      file_bytes[$urandom_range(start, file_bytes.size() - 1)].b = 8'($urandom_range(0, 255));
    if (file_bytes.size() == start) put_str("P");
    file_bytes[$].last = 1;
  endfunction

  function automatic void add_row(string txt, bit typed, logic [3:0] st = STAT_OK,
                                  logic [31:0] w = 0, logic [31:0] h = 0,
                                  logic [31:0] c = 0, logic [1:0] cc = 0, logic ec = 0);
    dir_row_t r;
    r.txt = txt;
    r.typed = typed;
    r.res = '{st, w, h, c, cc, ec};
    dir_tab.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    bi.valid = 0;
    bi.byte_in = '0;
    bi.last_byte = 0;
    calm = 0;
    hdr_reset();

    add_row("P5 1 1 255\nA", 1, STAT_OK, 1, 1, 1, 1, 0);
    add_row("P6 1 1 255\nABC", 1, STAT_OK, 1, 1, 3, 3, 0);
    add_row({"P7\nWIDTH 1\nHEIGHT 1\nDEPTH 4\nMAXVAL 255\nTUPLTYPE ", with_alpha("RGB"),
             "\nENDHDR\nABCD"}, 1, STAT_OK, 1, 1, 4, 3, 1);
    add_row({"P7\nTUPLTYPE ", with_alpha("GRAYSCALE"),
             "\nDEPTH 2\nWIDTH 2\nHEIGHT 1\nMAXVAL 255\n",
             "ENDHDR\nA\t#B"}, 1, STAT_OK, 2, 1, 2, 1, 1);
    add_row(" ", 1, STAT_NO_MAGIC);
    add_row("X", 1, STAT_BAD_MAGIC);
    add_row("P5", 1, STAT_BAD_WIDTH);
    add_row("P5 4294967296 1 255\nA", 1, STAT_BAD_WIDTH);
    add_row("P5 4294967295 1 255\nA", 1, STAT_SIZE);
    add_row("P5 1 -0 255\nA", 1, STAT_BAD_HEIGHT);
    add_row("P5 1 1 254\nA", 1, STAT_BAD_MAXVAL);
    add_row("P7", 1, STAT_TRUNC_PAM);
    add_row("P7\nFOO 1", 1, STAT_UNKNOWN_KEY);
    add_row("P7\nWIDTH 1\nENDHDR\n", 1, STAT_INCOMPLETE);
    add_row("P7\nWIDTH", 1, STAT_BAD_WIDTH);
    add_row("P7\nTUPLTYPE", 1, STAT_NO_TUPLE);
    add_row({"P7 WIDTH 1 HEIGHT 1 DEPTH 1 MAXVAL 255 TUPLTYPE BLUE ENDHDR\nA"}, 1,
            STAT_BAD_TUPLE);
    add_row({"P7 WIDTH 1 HEIGHT 1 DEPTH 1 MAXVAL 255 TUPLTYPE RGB ENDHDR\nA"}, 1,
            STAT_DEPTH_MISM);
    add_row(repeat_str("P", 64), 1, STAT_NO_MAGIC);
    add_row(repeat_str("P", 63), 0);
    add_row({"P7\n", repeat_str("W", 70)}, 1, STAT_TRUNC_PAM);
    add_row("P5 +2 1 255 #c\n\t#x\n AB", 0);
    add_row("P5#w\n1 1 255\n\n\nA", 0);
    add_row("P7 WIDTH 3 WIDTH 1 HEIGHT 1 DEPTH 3 MAXVAL 255 TUPLTYPE RGB ENDHDR\nabc", 0);

    foreach (dir_tab[i]) begin
      put_str(dir_tab[i].txt);
      file_bytes[$].last = 1;
      file_bytes[$].typed = dir_tab[i].typed;
      file_bytes[$].res = dir_tab[i].res;
    end
    while (file_bytes.size() < 1600) gen_file();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (file_bytes[i]) begin
      if (i > file_bytes.size() * 9 / 10) calm = 1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        bi.valid = 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      bi.valid = 1;
      bi.byte_in = file_bytes[i].b;
      bi.last_byte = file_bytes[i].last;
      do @(posedge clk); while (!bi.ready);
      @(negedge clk);
    end
    bi.valid = 0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (results_due.size() != 0) nerr++;
    if (nerr == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    ri.ready = 0;
    forever begin
      @(negedge clk);
      if (!rst && !calm && $urandom_range(0, 5) == 0) begin
        ri.ready = 0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        ri.ready = 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // prediction and checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hdr_result_t got, want;
    if (!rst && bi.valid && bi.ready) begin
      hdr_byte(bi.byte_in);
      if (bi.last_byte) begin
        want = hdr_close();
        // typed rows override the predictor for that file
        if (file_bytes[fed].typed) want = file_bytes[fed].res;
        results_due.push_back(want);
      end
      fed++;
    end
    if (!rst && ri.valid && ri.ready) begin
      got = '{ri.status, ri.width, ri.height, ri.channels, ri.color_channels,
              ri.extra_channels};
      if (results_due.size() == 0) begin
        nerr++;
        if (nerr <= 10) $display("unexpected result: status %0d", got.status);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          nerr++;
          if (nerr <= 10)
            $display({"mismatch: exp st %0d w %0d h %0d ch %0d cc %0d ec %0d, ",
                      "got st %0d w %0d h %0d ch %0d cc %0d ec %0d"},
                     want.status, want.width, want.height, want.channels,
                     want.color_channels, want.extra_channels, got.status, got.width,
                     got.height, got.channels, got.color_channels, got.extra_channels);
        end
      end
    end
  end

  // Stop a run in which neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (bi.valid && bi.ready) || (ri.valid && ri.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
